FILE: hw/rtl/fpa_pkg.sv
// Shared types and constants of the fixed-point atan2 pipeline.
// No dependencies; every file but the checker uses it by scoped names.
package fpa_pkg;

    // Quotient bits formed by the divider, one per cell.
    localparam int DivSteps = 31;
    localparam int PolyTerms = 5;
    localparam int RotShift = 13;
    localparam logic [15:0] MinusPi = 16'h8000;
    localparam logic [15:0] SatPos = 16'h7FFF;
    localparam logic [15:0] SatNeg = 16'h8000;

    // Horner coefficients, highest order first.
    localparam logic signed [15:0] PolyCoef [PolyTerms] = '{
        16'shFED4, 16'sh08C6, 16'shEF3E, 16'sh006D, 16'sh28BD
    };

    // Item travelling down the divider chain.
    typedef struct packed {
        logic [15:0]         rem;      // partial remainder
        logic [DivSteps-1:0] dvd;      // dividend bits still to enter
        logic [15:0]         quo;      // low quotient bits so far
        logic [15:0]         dsr;      // divisor magnitude
        logic                qneg;     // quotient sign
        logic                zdiv;     // divisor is zero
        logic                nneg;     // numerator negative
        logic [2:0]          rot;      // eighths of a turn
        logic                spec;     // zero imaginary part
        logic                specneg;  // zero imaginary, negative real
    } t_div;

    // Item travelling down the polynomial chain.
    typedef struct packed {
        logic signed [15:0] tan;
        logic signed [15:0] acc;
        logic [2:0]         rot;
        logic               spec;
        logic               specneg;
    } t_poly;

endpackage

FILE: hw/rtl/fixed_point_atan2.sv
// Registered stages, in order: fold, 31 divider cells, tangent, five
// polynomial cells, output register.
// Throughput: one item per cycle; the whole chain advances together and
// halts only while a finished result is held unaccepted at the output.
// Reset: synchronous, active low; clears every valid bit, payload is kept.
module fixed_point_atan2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_imag_part,
    input  logic [15:0] i_real_part,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_angle
);

    // The chain moves whenever the output register is empty or being drained.
    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Fold stage: the vector is rotated into the first octant while the eighths
    // of a turn are counted. Parts wrap at 16 bits; the diagonal sum has 17.
    logic signed [15:0] v_im;
    logic signed [15:0] v_re;
    logic signed [15:0] v_t;
    logic signed [16:0] v_full;
    logic [2:0]         v_rot;
    logic [15:0]        v_mag;
    fpa_pkg::t_div      n_fold;

    always_comb begin
        v_im = i_imag_part;
        v_re = i_real_part;
        v_rot = 3'd0;
        if (v_im < 0) begin
            v_im  = -v_im;
            v_re  = -v_re;
            v_rot = 3'd4;
        end
        if (v_re <= 0) begin
            v_t   = v_re;
            v_re  = v_im;
            v_im  = -v_t;
            v_rot = v_rot + 3'd2;
        end
        if (v_re <= v_im) begin
            v_t    = v_im - v_re;
            v_full = {v_re[15], v_re} + {v_im[15], v_im};
            if (v_full[15]) begin
                // The wrapped sum is negative, so both parts are halved.
                v_re = v_full[16:1];
                v_im = v_t >>> 1;
            end else begin
                v_re = v_full[15:0];
                v_im = v_t;
            end
            v_rot = v_rot + 3'd1;
        end else begin
            v_t    = '0;
            v_full = '0;
        end
        v_mag = v_im[15] ? 16'(-v_im) : v_im;

        n_fold.rem     = '0;
        n_fold.dvd     = {v_mag, 15'd0};
        n_fold.quo     = '0;
        n_fold.dsr     = v_re[15] ? 16'(-v_re) : v_re;
        n_fold.qneg    = v_im[15] ^ v_re[15];
        n_fold.zdiv    = (v_re == 0);
        n_fold.nneg    = v_im[15];
        n_fold.rot     = v_rot;
        n_fold.spec    = (i_imag_part == 16'd0);
        n_fold.specneg = i_real_part[15];
    end

    logic          r_fold_valid;
    fpa_pkg::t_div r_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (w_adv) begin
            r_fold_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fold <= n_fold;
        end
    end

    // Divider: a row of restoring cells, one quotient bit each.
    logic          w_dv [fpa_pkg::DivSteps+1];
    fpa_pkg::t_div w_dd [fpa_pkg::DivSteps+1];
    assign w_dv[0] = r_fold_valid;
    assign w_dd[0] = r_fold;

    for (genvar g = 0; g < fpa_pkg::DivSteps; g++) begin : g_div
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dv[g]),
            .i_d     (w_dd[g]),
            .o_valid (w_dv[g+1]),
            .o_d     (w_dd[g+1])
        );
    end

    // Tangent stage: apply the quotient sign, or saturate on a zero divisor.
    fpa_pkg::t_div  w_dq;
    fpa_pkg::t_poly n_tan;
    assign w_dq = w_dd[fpa_pkg::DivSteps];

    always_comb begin
        if (w_dq.zdiv) begin
            n_tan.tan = w_dq.nneg ? fpa_pkg::SatNeg : fpa_pkg::SatPos;
        end else begin
            n_tan.tan = w_dq.qneg ? 16'(-w_dq.quo) : w_dq.quo;
        end
        n_tan.acc     = '0;
        n_tan.rot     = w_dq.rot;
        n_tan.spec    = w_dq.spec;
        n_tan.specneg = w_dq.specneg;
    end

    logic           r_tan_valid;
    fpa_pkg::t_poly r_tan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tan_valid <= 1'b0;
        end else if (w_adv) begin
            r_tan_valid <= w_dv[fpa_pkg::DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tan <= n_tan;
        end
    end

    // Polynomial: one Horner step per cell, each with its own multiplier.
    logic           w_pv [fpa_pkg::PolyTerms+1];
    fpa_pkg::t_poly w_pp [fpa_pkg::PolyTerms+1];
    assign w_pv[0] = r_tan_valid;
    assign w_pp[0] = r_tan;

    for (genvar g = 0; g < fpa_pkg::PolyTerms; g++) begin : g_poly
        fpa_poly_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_coef  (fpa_pkg::PolyCoef[g]),
            .i_valid (w_pv[g]),
            .i_p     (w_pp[g]),
            .o_valid (w_pv[g+1]),
            .o_p     (w_pp[g+1])
        );
    end

    // Output register: add the octant offset, or give the zero-imaginary angle.
    fpa_pkg::t_poly w_pf;
    logic [15:0]    n_angle;
    logic           r_out_valid;
    logic [15:0]    r_angle;
    assign w_pf = w_pp[fpa_pkg::PolyTerms];

    always_comb begin
        if (w_pf.spec) begin
            n_angle = w_pf.specneg ? fpa_pkg::MinusPi : 16'd0;
        end else begin
            n_angle = w_pf.acc + {w_pf.rot, fpa_pkg::RotShift'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_pv[fpa_pkg::PolyTerms];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_angle <= n_angle;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_angle;

endmodule

FILE: hw/rtl/fpa_div_cell.sv
// One restoring-division cell: forms one quotient bit per item.
// Depends on fpa_pkg.
module fpa_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  fpa_pkg::t_div i_d,
    output logic          o_valid,
    output fpa_pkg::t_div o_d
);

    logic          r_valid;
    fpa_pkg::t_div r_d;
    fpa_pkg::t_div n_d;
    logic [16:0]   w_trial;
    logic          w_ge;

    always_comb begin
        w_trial = {i_d.rem, i_d.dvd[fpa_pkg::DivSteps-1]};
        w_ge    = w_trial >= {1'b0, i_d.dsr};
        n_d     = i_d;
        n_d.rem = w_ge ? 16'(w_trial - {1'b0, i_d.dsr}) : w_trial[15:0];
        n_d.dvd = {i_d.dvd[fpa_pkg::DivSteps-2:0], 1'b0};
        n_d.quo = {i_d.quo[14:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

FILE: hw/rtl/fpa_poly_cell.sv
// One Horner step: add a coefficient, multiply by the tangent, saturate.
// Depends on fpa_pkg.
module fpa_poly_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [15:0] i_coef,
    input  logic               i_valid,
    input  fpa_pkg::t_poly     i_p,
    output logic               o_valid,
    output fpa_pkg::t_poly     o_p
);

    logic               r_valid;
    fpa_pkg::t_poly     r_p;
    fpa_pkg::t_poly     n_p;
    logic signed [15:0] w_sum;
    logic signed [31:0] w_prod;
    logic signed [16:0] w_sh;

    always_comb begin
        w_sum  = i_p.acc + i_coef;
        w_prod = w_sum * i_p.tan;
        w_sh   = w_prod[31:15];
        n_p    = i_p;
        if (w_sh > 17'sh07FFF) begin
            n_p.acc = fpa_pkg::SatPos;
        end else if (w_sh < -17'sh08000) begin
            n_p.acc = fpa_pkg::SatNeg;
        end else begin
            n_p.acc = w_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;

endmodule

FILE: hw/rtl/fpa_checker.sv
// Port-level checks on the atan2 pipeline, bound to the top level.
// Depends on fixed_point_atan2's ports only.
module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_angle
);

    // Input is taken exactly when the output side can move.
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    // A held result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_angle))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind fixed_point_atan2 fpa_checker u_fpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_angle     (o_angle)
);

FILE: dv/fixed_point_atan2_test.sv
// Self-checking testbench of the fixed-point atan2 pipeline, top level fixed_point_atan2.
// Depends on fpa_pkg for the minus-pi and rotation constants; no files are read.
`timescale 1ns / 1ps

module fixed_point_atan2_test;

    localparam int ItemTarget = 1300;
    localparam int Latency    = 39;
    localparam int StallLimit = 20000;

    // Idling schemes, in the order they are run.
    typedef enum int {SendIdle, RecvIdle, NoIdle} t_idle_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_imag_part;
    logic [15:0] i_real_part;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_angle;

    int         mismatch_count = 0;
    int         idle_pct_send;
    int         idle_pct_recv;
    int         quiet_cycles = 0;
    bit         watchdog_fired = 1'b0;
    t_idle_mode idle_mode;

    fixed_point_atan2 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_imag_part (i_imag_part),
        .i_real_part (i_real_part),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_angle     (o_angle)
    );

    // Wraps a wide signed value to 16 bits.
    function automatic logic signed [15:0] to16(input longint v);
        logic [15:0] bits;
        bits = v[15:0];
        return $signed(bits);
    endfunction

    function automatic int clip16(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    // Predicted angle of one vector: fold into the first octant, divide, then
    // run the Horner polynomial and add the rotation in eighths of a turn.
    function automatic logic [15:0] predict_angle(input logic [15:0] imag_in,
                                                  input logic [15:0] real_in);
        longint im, re, tmp, num, tang, acc;
        int     rot;
        longint coef [5];
        coef = '{-'sh012C, 'sh08C6, -'sh10C2, 'sh006D, 'sh28BD};
        im  = longint'($signed(imag_in));
        re  = longint'($signed(real_in));
        rot = 0;
        if (im == 0) begin
            return (re < 0) ? fpa_pkg::MinusPi : 16'h0000;
        end
        if (im < 0) begin
            im  = to16(-im);
            re  = to16(-re);
            rot += 4;
        end
        if (re <= 0) begin
            tmp = re;
            re  = im;
            im  = to16(-tmp);
            rot += 2;
        end
        if (re <= im) begin
            // A wrapped sum that turns negative means overflow: halve both.
            if (to16(re + im) < 0) begin
                tmp = to16(im - re);
                re  = to16((re + im) >>> 1);
                im  = tmp >>> 1;
            end else begin
                tmp = to16(im - re);
                re  = to16(re + im);
                im  = tmp;
            end
            rot += 1;
        end
        num = im * 32768;
        if (re == 0) begin
            tang = (num >= 0) ? 32767 : -32768;
        end else begin
            tang = to16(num / re);
        end
        acc = 0;
        for (int k = 0; k < 5; k++) begin
            acc = to16(acc + coef[k]);
            acc = clip16((acc * tang) >>> 15);
        end
        return to16(acc + (longint'(rot) << fpa_pkg::RotShift));
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Keeps the angles still owed by the block, oldest first.
    class angle_scoreboard;
        logic [15:0] pending_angles[$];
        int          checked;

        function void note_vector(input logic [15:0] imag_in, input logic [15:0] real_in);
            pending_angles.push_back(predict_angle(imag_in, real_in));
        endfunction

        task check_angle(input logic [15:0] got);
            logic [15:0] want;
            checked++;
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("unexpected angle %h", got));
            end else begin
                want = pending_angles.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("angle %h, expected %h", got, want));
                end
            end
        endtask
    endclass

    angle_scoreboard angle_sb;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sends one vector; valid is held until the item is taken.
    task automatic send_vector(input logic [15:0] imag_in, input logic [15:0] real_in);
        while ($urandom_range(99, 0) < idle_pct_send) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_imag_part <= imag_in;
        i_real_part <= real_in;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        angle_sb.note_vector(imag_in, real_in);
        @(negedge i_clk);
    endtask

    // Random vector: mostly random bits, sometimes an edge value per part.
    function automatic logic [15:0] pick_part();
        logic [15:0] edges [7];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8001, 16'h4000};
        if ($urandom_range(7, 0) == 0) begin
            return edges[$urandom_range(6, 0)];
        end
        return 16'($urandom());
    endfunction

    // Receiver: stalls at random while idle_pct_recv is nonzero, and checks every angle it takes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= idle_pct_recv);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            angle_sb.check_angle(o_angle);
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit && !watchdog_fired) begin
                watchdog_fired = 1'b1;
                $display("watchdog: no item moved in %0d cycles", StallLimit);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] corners [8];
        int          per_phase;
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                    16'hFFFF, 16'h8001, 16'h4000, 16'hC000};
        angle_sb       = new();
        idle_pct_send  = 37;
        idle_pct_recv  = 53;
        idle_mode      = SendIdle;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_imag_part    = '0;
        i_real_part    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed vectors: zero imaginary with each real sign, the most
        // negative parts (negation wraps), the diagonals where the overflowing
        // sum is halved, a zero folded real part, and each octant.
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h0000, 16'h0005);
        send_vector(16'h0000, 16'h8000);
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                send_vector(corners[a], corners[b]);
            end
        end
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h8001);
        send_vector(16'h6000, 16'h5000);
        send_vector(16'hC000, 16'h4000);
        send_vector(16'h0001, 16'h8000);

        per_phase = ItemTarget / 3;
        for (int phase = 0; phase < 3; phase++) begin
            idle_mode = t_idle_mode'(phase);
            case (idle_mode)
                SendIdle: begin
                    idle_pct_send = 37;
                    idle_pct_recv = 53;
                end
                RecvIdle: begin
                    idle_pct_send = 53;
                    idle_pct_recv = 37;
                end
                default: begin
                    idle_pct_send = 0;
                    idle_pct_recv = 0;
                end
            endcase
            for (int n = 0; n < per_phase; n++) begin
                send_vector(pick_part(), pick_part());
            end
        end
        i_in_valid <= 1'b0;

        while (angle_sb.pending_angles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (Latency + 10) @(posedge i_clk);

        $display("covered %0d angles over directed corners and three idling schemes",
                 angle_sb.checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches seen", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_div_cell.sv
hw/rtl/fpa_poly_cell.sv
hw/rtl/fixed_point_atan2.sv
hw/rtl/fpa_checker.sv
dv/fixed_point_atan2_test.sv
